// File: rtl/rabin_rolling_fingerprint_macros.svh
// Assertion macros shared by the fingerprint checker.
`ifndef RABIN_ROLLING_FINGERPRINT_MACROS_SVH
`define RABIN_ROLLING_FINGERPRINT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RRF_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("rrf assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define RRF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("rrf assertion failed");

`endif

// File: rtl/rrf_pkg.sv
// Types, constants and GF(2) helpers for the rolling fingerprint.
package rrf_pkg;

  localparam int unsigned DigestW = 64;
  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned TabLen  = 8;

  typedef logic [DigestW-1:0] word_t;
  typedef word_t [TabLen-1:0] gf_tab_t;

  // Register indexes of the configuration port.
  localparam logic [CfgIdxW-1:0] RegPoly   = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegRemove = CfgIdxW'(1);

  localparam word_t PolyReset   = word_t'(27);
  localparam word_t RemoveReset = word_t'(0);

  typedef struct packed {
    gf_tab_t red_tab;  // poly * x^i mod P: reduces the byte shifted out
    gf_tab_t rem_tab;  // removal factor * x^i mod P: removes the leaving byte
  } rrf_tabs_t;

  typedef struct packed {
    logic [7:0] leave_byte;
    logic       full;
  } rrf_win_t;

  function automatic word_t gf_times_x(input word_t r, input word_t poly);
    return {r[DigestW-2:0], 1'b0} ^ (r[DigestW-1] ? poly : '0);
  endfunction

  // Entry i holds f * x^i mod P.
  function automatic gf_tab_t build_tab(input word_t f, input word_t poly);
    gf_tab_t tab;
    tab[0] = f;
    for (int i = 1; i < TabLen; i++) begin
      tab[i] = gf_times_x(tab[i-1], poly);
    end
    return tab;
  endfunction

  // Product of an 8-bit polynomial with the value whose table is given.
  function automatic word_t gf_tab_mul(input logic [7:0] b, input gf_tab_t tab);
    word_t acc;
    acc = '0;
    for (int i = 0; i < TabLen; i++) begin
      if (b[i]) begin
        acc = acc ^ tab[i];
      end
    end
    return acc;
  endfunction

  localparam gf_tab_t PolyResetTab   = build_tab(PolyReset, PolyReset);
  localparam gf_tab_t RemoveResetTab = build_tab(RemoveReset, PolyReset);

endpackage

// File: rtl/rrf_cfg.sv
// Configuration registers, kept as precomputed multiplication tables.
module rrf_cfg
  import rrf_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  word_t              cfg_data_i,
  output rrf_tabs_t          tabs_o
);

  gf_tab_t red_q, red_d;
  gf_tab_t rem_q, rem_d;
  word_t   poly_sel;
  word_t   rem_sel;

  // Entry zero of each table is the register value itself. A new polynomial
  // also rebuilds the removal table, since its entries are reduced mod P.
  always_comb begin
    poly_sel = (cfg_index_i == RegPoly)   ? cfg_data_i : red_q[0];
    rem_sel  = (cfg_index_i == RegRemove) ? cfg_data_i : rem_q[0];
    red_d    = build_tab(poly_sel, poly_sel);
    rem_d    = build_tab(rem_sel, poly_sel);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      red_q <= PolyResetTab;
      rem_q <= RemoveResetTab;
    end else if (cfg_valid_i) begin
      red_q <= red_d;
      rem_q <= rem_d;
    end
  end

  assign tabs_o.red_tab = red_q;
  assign tabs_o.rem_tab = rem_q;

endmodule

// File: rtl/rrf_window.sv
// Byte window as a shift line, with the fill counter.
module rrf_window
  import rrf_pkg::*;
#(
  parameter int unsigned WINDOW_LEN = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic       restart_i,
  input  logic [7:0] byte_i,
  output rrf_win_t   win_o
);

  localparam int unsigned CntW = $clog2(WINDOW_LEN + 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(WINDOW_LEN);

  logic [7:0]      line_q [WINDOW_LEN];
  logic [CntW-1:0] fill_q, fill_d;
  logic            was_full;

  // The last tap holds the oldest byte once the window has filled; before
  // that, and on a restart, nothing leaves.
  always_comb begin
    was_full = (fill_q == FullCnt) && !restart_i;
    if (restart_i) begin
      fill_d = CntW'(1);
    end else if (fill_q == FullCnt) begin
      fill_d = FullCnt;
    end else begin
      fill_d = fill_q + CntW'(1);
    end
  end

  assign win_o.leave_byte = was_full ? line_q[WINDOW_LEN-1] : 8'h00;
  assign win_o.full       = (fill_d == FullCnt);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else if (step_i) begin
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      line_q[0] <= byte_i;
      for (int i = 1; i < WINDOW_LEN; i++) begin
        line_q[i] <= line_q[i-1];
      end
    end
  end

endmodule

// File: rtl/rrf_digest.sv
// Rolling digest register and its one-byte update.
module rrf_digest
  import rrf_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic       restart_i,
  input  logic [7:0] byte_i,
  input  rrf_win_t   win_i,
  input  rrf_tabs_t  tabs_i,
  output word_t      digest_o
);

  word_t digest_q, digest_d;
  word_t removed;

  always_comb begin
    removed  = (restart_i ? '0 : digest_q) ^ gf_tab_mul(win_i.leave_byte, tabs_i.rem_tab);
    digest_d = {removed[DigestW-9:0], byte_i}
             ^ gf_tab_mul(removed[DigestW-1:DigestW-8], tabs_i.red_tab);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digest_q <= '0;
    end else if (step_i) begin
      digest_q <= digest_d;
    end
  end

  assign digest_o = digest_d;

endmodule

// File: rtl/rabin_rolling_fingerprint.sv
// Rolling Rabin fingerprint over a byte stream: one byte per cycle unless stalled, 64-bit digest mod P.
// The block takes one byte per word and returns one result word per byte: the
// digest of the last WINDOW_LEN bytes mod P and a flag that is high once a full
// window has arrived since the last restart. It sustains one byte per clock
// while the output is not stalled; a byte's result passes the input register
// and the result register; the rate is set by the digest feedback register, whose
// update is two chained 8-term XOR trees. Register 0 is the low 64 bits of P
// (x^64 implicit, reset 27); register 1 is x^(8*(WINDOW_LEN-1)) mod P, which
// software loads (reset 0, so no byte is removed). A configuration write
// applies to every byte whose digest is computed after it, so a byte that waits
// in the input register uses the new value. There is no clearing pass after reset.
module rabin_rolling_fingerprint
  import rrf_pkg::*;
#(
  parameter int unsigned WINDOW_LEN = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         data_byte_i,
  input  logic               restart_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [63:0]        digest_o,
  output logic               window_full_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [63:0]        cfg_data_i
);

  logic       s1_valid_q;
  logic [7:0] s1_byte_q;
  logic       s1_restart_q;
  logic       out_valid_q;
  word_t      out_digest_q;
  logic       out_full_q;

  logic       advance;
  logic       step;
  logic       in_accept;
  rrf_tabs_t  tabs;
  rrf_win_t   win;
  word_t      digest_next;

  assign advance    = !out_valid_q || !out_stall_i;
  assign step       = s1_valid_q && advance;
  assign in_stall_o = s1_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  rrf_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .tabs_o      (tabs)
  );

  rrf_window #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_window (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .restart_i (s1_restart_q),
    .byte_i    (s1_byte_q),
    .win_o     (win)
  );

  rrf_digest u_digest (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .restart_i (s1_restart_q),
    .byte_i    (s1_byte_q),
    .win_i     (win),
    .tabs_i    (tabs),
    .digest_o  (digest_next)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        s1_valid_q <= 1'b1;
      end else if (step) begin
        s1_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_byte_q    <= data_byte_i;
      s1_restart_q <= restart_i;
    end
    if (step) begin
      out_digest_q <= digest_next;
      out_full_q   <= win.full;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign digest_o      = out_digest_q;
  assign window_full_o = out_full_q;
  assign cfg_ready_o   = 1'b1;

endmodule

// File: rtl/rrf_checker.sv
// Port-level checks of the fingerprint block, bound to the top level.
`include "rabin_rolling_fingerprint_macros.svh"

module rrf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [63:0] digest_o,
  input logic        window_full_o
);

  // A waiting result word holds its value.
  `RRF_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(digest_o) && $stable(window_full_o))

  // The input side only stalls when a result word is held back.
  `RRF_ASSERT_IMPLY(a_stall_cause, clk_i, rst_ni, in_stall_o, out_valid_o && out_stall_i)

  // A result word after an empty cycle comes from a byte taken into the input register and passed on without a stall.
  `RRF_ASSERT_IMPLY(a_out_source, clk_i, rst_ni, $rose(out_valid_o), $past(in_valid_i && !in_stall_o, 2))

endmodule

bind rabin_rolling_fingerprint rrf_checker u_rrf_checker (.*);
